>>> hdl/fxlms_pkg.sv
`default_nettype none

package fxlms_pkg;

  localparam logic [1:0] CMD_PROCESS  = 2'd0;
  localparam logic [1:0] CMD_WR_ADAPT = 2'd1;
  localparam logic [1:0] CMD_WR_MODEL = 2'd2;

  localparam logic [1:0] CFG_ADAPT_STEP = 2'd0;
  localparam logic [1:0] CFG_MODEL_STEP = 2'd1;
  localparam logic [1:0] CFG_LEAK       = 2'd2;
  localparam logic [1:0] CFG_WARMUP     = 2'd3;

  localparam int CountW = 21;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [15:0]  reference_sample;
    logic signed [15:0]  error_sample;
    logic [5:0]          coef_index;
    logic signed [63:0]  coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  drive_sample;
    logic                drive_valid;
    logic signed [15:0]  model_error;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIR,
    S_FIR_END,
    S_UPD,
    S_FIN
  } state_e;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] leak64(input logic signed [63:0] c,
                                                input logic [5:0] ls);
    logic signed [63:0] t;
    t = c >>> ls;
    return sat_sub64(c, t);
  endfunction

  function automatic logic signed [63:0] scale_step(input logic signed [39:0] g,
                                                    input logic [5:0] sh);
    logic signed [63:0] ge;
    logic signed [96:0] w;
    logic [5:0] s;
    ge = 64'(g);
    if (sh >= 6'd56) begin
      return ge >>> (sh - 6'd56);
    end
    s = 6'd56 - sh;
    w = 97'(g) <<< s;
    if (w[96:63] != {34{w[63]}}) begin
      return g[39] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return w[63:0];
  endfunction

  function automatic logic signed [15:0] sat33_16(input logic signed [32:0] v);
    if (v > 33'sd32767) return 16'sh7fff;
    if (v < -33'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat32_24(input logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sh7fffff;
    if (v < -32'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic [7:0] circ_addr(input logic [7:0] head, input logic [7:0] age,
                                           input logic [7:0] depth);
    logic [7:0] t;
    t = head + depth - age;
    if (t >= depth) t = t - depth;
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hdl/fxlms_noise_canceller.sv
// A coefficient write goes from idle straight to S_FIN; a sample pair first runs one
// filter pass and one update pass, each walking max(ADAPT_TAPS, MODEL_TAPS) tap
// entries one per cycle. In S_FIN the result moves into the output register once the
// output is not stalled. Only one item is handled at a time; the next item is taken the
// cycle after the previous one has moved into the output register.
// Reset clears control state; histories and coefficients read as zero until written.
`default_nettype none

module fxlms_noise_canceller #(
  parameter int ADAPT_TAPS = 64,
  parameter int MODEL_TAPS = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  fxlms_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output fxlms_pkg::out_item_t  out_item_o,
  input  wire                   cfg_we_i,
  input  wire [1:0]             cfg_index_i,
  input  wire [19:0]            cfg_data_i
);
  import fxlms_pkg::*;

  localparam int REF_DEPTH = (ADAPT_TAPS > MODEL_TAPS) ? ADAPT_TAPS : MODEL_TAPS;
  localparam int RAW = $clog2(REF_DEPTH);
  localparam int AAW = $clog2(ADAPT_TAPS);
  localparam int MAW = $clog2(MODEL_TAPS);
  localparam int JW  = $clog2(REF_DEPTH + 1);
  localparam int RFW = $clog2(REF_DEPTH + 1);
  localparam int AFW = $clog2(ADAPT_TAPS + 1);
  localparam int MFW = $clog2(MODEL_TAPS + 1);

  logic [5:0]  adapt_shift_q, model_shift_q, leak_shift_q;
  logic [19:0] warmup_q;

  state_e state_q, state_d;
  logic [JW-1:0] j_q;
  logic [CountW-1:0] count_q, count_inc;
  logic vflag_q, proc_q;
  logic [RAW-1:0] ref_head_q, ref_head_nx;
  logic [AAW-1:0] frh_head_q, frh_head_nx;
  logic [MAW-1:0] drv_head_q, drv_head_nx;
  logic [RFW-1:0] ref_fill_q;
  logic [AFW-1:0] frh_fill_q;
  logic [MFW-1:0] drv_fill_q;
  logic avalid_q [ADAPT_TAPS];
  logic mvalid_q [MODEL_TAPS];

  logic signed [15:0] ref_mem [REF_DEPTH];
  logic signed [23:0] frh_mem [ADAPT_TAPS];
  logic signed [15:0] drv_mem [MODEL_TAPS];
  logic signed [63:0] ac_mem  [ADAPT_TAPS];
  logic signed [63:0] mc_mem  [MODEL_TAPS];
  logic signed [15:0] ref_rd_q, drv_rd_q;
  logic signed [23:0] frh_rd_q;
  logic signed [63:0] ac_rd_q, mc_rd_q;

  logic accept, issue, is_proc, free_out;
  logic [7:0] j8, ref_ra8, frh_ra8, drv_ra8;
  logic [RAW-1:0] ref_raddr;
  logic [AAW-1:0] frh_raddr, ac_idx;
  logic [MAW-1:0] drv_raddr, mc_idx;
  logic j_in_a, j_in_m, ac_ok, mc_ok;

  logic f1_v_q, f2_v_q, u1_v_q, u2_v_q, u3_v_q;
  logic ref_ok_q, drv_ok_q, frh_ok_q, ac_ok_q, mc_ok_q, ado1_q, mdo1_q;
  logic ado2_q, mdo2_q, ado3_q, mdo3_q;
  logic [JW-1:0] j1_q, j2_q, j3_q;

  logic signed [15:0] e_q, y_q, es_q;
  logic signed [15:0] ref_m, drv_m;
  logic signed [23:0] frh_m, xc;
  logic signed [63:0] ac_m, mc_m;
  logic signed [55:0] pa_q, px_q, pd_q;
  logic signed [63:0] acc_y_q, acc_x_q, acc_d_q;
  logic signed [39:0] ga_q, gm_q;
  logic signed [63:0] ca_q, cm_q, sa_q, sm_q, la_q, lm_q, na, nm;
  logic signed [31:0] ys;

  logic ac_we, mc_we;
  logic [AAW-1:0] ac_waddr;
  logic [MAW-1:0] mc_waddr;
  logic signed [63:0] ac_wdata, mc_wdata;
  logic cmd_wa, cmd_wm;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign is_proc    = (in_item_i.cmd == CMD_PROCESS);
  assign free_out   = !out_valid_o || !out_stall_i;
  assign issue      = ((state_q == S_FIR) || (state_q == S_UPD)) && (j_q < JW'(REF_DEPTH));

  assign count_inc   = (count_q == {CountW{1'b1}}) ? count_q : count_q + 1'b1;
  assign ref_head_nx = (ref_head_q == RAW'(REF_DEPTH - 1)) ? '0 : ref_head_q + 1'b1;
  assign frh_head_nx = (frh_head_q == AAW'(ADAPT_TAPS - 1)) ? '0 : frh_head_q + 1'b1;
  assign drv_head_nx = (drv_head_q == MAW'(MODEL_TAPS - 1)) ? '0 : drv_head_q + 1'b1;

  assign j8        = 8'(j_q);
  assign ref_ra8   = circ_addr(8'(ref_head_q), j8, 8'(REF_DEPTH));
  assign frh_ra8   = circ_addr(8'(frh_head_q), j8, 8'(ADAPT_TAPS));
  assign drv_ra8   = circ_addr(8'(drv_head_q), j8, 8'(MODEL_TAPS));
  assign ref_raddr = ref_ra8[RAW-1:0];
  assign frh_raddr = frh_ra8[AAW-1:0];
  assign drv_raddr = drv_ra8[MAW-1:0];
  assign ac_idx    = j_q[AAW-1:0];
  assign mc_idx    = j_q[MAW-1:0];
  assign j_in_a    = j8 < 8'(ADAPT_TAPS);
  assign j_in_m    = j8 < 8'(MODEL_TAPS);
  assign ac_ok     = j_in_a && avalid_q[ac_idx];
  assign mc_ok     = j_in_m && mvalid_q[mc_idx];

  assign cmd_wa = accept && (in_item_i.cmd == CMD_WR_ADAPT) &&
                  (7'(in_item_i.coef_index) < 7'(ADAPT_TAPS));
  assign cmd_wm = accept && (in_item_i.cmd == CMD_WR_MODEL) &&
                  (7'(in_item_i.coef_index) < 7'(MODEL_TAPS));

  assign na = sat_sub64(la_q, sa_q);
  assign nm = sat_add64(lm_q, sm_q);

  assign ac_we    = cmd_wa || (u3_v_q && ado3_q);
  assign ac_waddr = cmd_wa ? in_item_i.coef_index[AAW-1:0] : j3_q[AAW-1:0];
  assign ac_wdata = cmd_wa ? in_item_i.coef_value : na;
  assign mc_we    = cmd_wm || (u3_v_q && mdo3_q);
  assign mc_waddr = cmd_wm ? in_item_i.coef_index[MAW-1:0] : j3_q[MAW-1:0];
  assign mc_wdata = cmd_wm ? in_item_i.coef_value : nm;

  assign ref_m = ref_ok_q ? ref_rd_q : '0;
  assign drv_m = drv_ok_q ? drv_rd_q : '0;
  assign frh_m = frh_ok_q ? frh_rd_q : '0;
  assign ac_m  = ac_ok_q ? ac_rd_q : '0;
  assign mc_m  = mc_ok_q ? mc_rd_q : '0;

  assign ys = acc_d_q[63:32];
  assign xc = sat32_24(acc_x_q[63:32]);

  always_ff @(posedge clk_i) begin
    if (accept && is_proc) begin
      ref_mem[ref_head_nx] <= in_item_i.reference_sample;
    end
    ref_rd_q <= ref_mem[ref_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIR_END) begin
      frh_mem[frh_head_nx] <= xc;
    end
    frh_rd_q <= frh_mem[frh_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_d == S_FIN && state_q == S_UPD) begin
      drv_mem[drv_head_nx] <= y_q;
    end
    drv_rd_q <= drv_mem[drv_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ac_we) begin
      ac_mem[ac_waddr] <= ac_wdata;
    end
    ac_rd_q <= ac_mem[ac_idx];
  end

  always_ff @(posedge clk_i) begin
    if (mc_we) begin
      mc_mem[mc_waddr] <= mc_wdata;
    end
    mc_rd_q <= mc_mem[mc_idx];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = is_proc ? S_FIR : S_FIN;
      end
      S_FIR: begin
        if (!issue && !f1_v_q && !f2_v_q) state_d = S_FIR_END;
      end
      S_FIR_END: state_d = S_UPD;
      S_UPD: begin
        if (!issue && !u1_v_q && !u2_v_q && !u3_v_q) state_d = S_FIN;
      end
      S_FIN: begin
        if (free_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      adapt_shift_q <= 6'd46;
      model_shift_q <= 6'd46;
      leak_shift_q  <= 6'd53;
      warmup_q      <= 20'd40000;
      j_q           <= '0;
      count_q       <= '0;
      vflag_q       <= 1'b0;
      proc_q        <= 1'b0;
      ref_head_q    <= '0;
      frh_head_q    <= '0;
      drv_head_q    <= '0;
      ref_fill_q    <= '0;
      frh_fill_q    <= '0;
      drv_fill_q    <= '0;
      out_valid_o   <= 1'b0;
      f1_v_q        <= 1'b0;
      f2_v_q        <= 1'b0;
      u1_v_q        <= 1'b0;
      u2_v_q        <= 1'b0;
      u3_v_q        <= 1'b0;
      for (int i = 0; i < ADAPT_TAPS; i++) avalid_q[i] <= 1'b0;
      for (int i = 0; i < MODEL_TAPS; i++) mvalid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ADAPT_STEP: adapt_shift_q <= cfg_data_i[5:0];
          CFG_MODEL_STEP: model_shift_q <= cfg_data_i[5:0];
          CFG_LEAK:       leak_shift_q  <= cfg_data_i[5:0];
          CFG_WARMUP:     warmup_q      <= cfg_data_i;
          default:        ;
        endcase
      end
      if (accept) begin
        proc_q <= is_proc;
        j_q    <= '0;
        if (is_proc) begin
          count_q    <= count_inc;
          vflag_q    <= count_inc > CountW'(warmup_q);
          ref_head_q <= ref_head_nx;
          if (ref_fill_q != RFW'(REF_DEPTH)) ref_fill_q <= ref_fill_q + 1'b1;
        end
      end else if (issue) begin
        j_q <= j_q + 1'b1;
      end
      if (state_q == S_FIR_END) begin
        j_q        <= '0;
        frh_head_q <= frh_head_nx;
        if (frh_fill_q != AFW'(ADAPT_TAPS)) frh_fill_q <= frh_fill_q + 1'b1;
      end
      if (state_q == S_UPD && state_d == S_FIN) begin
        drv_head_q <= drv_head_nx;
        if (drv_fill_q != MFW'(MODEL_TAPS)) drv_fill_q <= drv_fill_q + 1'b1;
      end
      if (cmd_wa) avalid_q[in_item_i.coef_index[AAW-1:0]] <= 1'b1;
      if (cmd_wm) mvalid_q[in_item_i.coef_index[MAW-1:0]] <= 1'b1;
      if (u3_v_q && ado3_q) avalid_q[j3_q[AAW-1:0]] <= 1'b1;
      if (u3_v_q && mdo3_q) mvalid_q[j3_q[MAW-1:0]] <= 1'b1;
      f1_v_q <= issue && (state_q == S_FIR);
      f2_v_q <= f1_v_q;
      u1_v_q <= issue && (state_q == S_UPD);
      u2_v_q <= u1_v_q;
      u3_v_q <= u2_v_q;
      if (state_q == S_FIN && free_out) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_q     <= in_item_i.error_sample;
      acc_y_q <= '0;
      acc_x_q <= '0;
      acc_d_q <= '0;
    end else if (f2_v_q) begin
      acc_y_q <= acc_y_q + 64'(pa_q);
      acc_x_q <= acc_x_q + 64'(px_q);
      acc_d_q <= acc_d_q + 64'(pd_q);
    end
    ref_ok_q <= j8 < 8'(ref_fill_q);
    drv_ok_q <= j_in_m && (j8 < 8'(drv_fill_q));
    frh_ok_q <= j_in_a && (j8 < 8'(frh_fill_q));
    ac_ok_q  <= ac_ok;
    mc_ok_q  <= mc_ok;
    ado1_q   <= j_in_a && vflag_q;
    mdo1_q   <= j_in_m;
    j1_q     <= j_q;
    pa_q     <= signed'(ac_m[63:24]) * ref_m;
    px_q     <= signed'(mc_m[63:24]) * ref_m;
    pd_q     <= signed'(mc_m[63:24]) * drv_m;
    ga_q     <= e_q * frh_m;
    gm_q     <= es_q * drv_m;
    ca_q     <= ac_m;
    cm_q     <= mc_m;
    ado2_q   <= ado1_q;
    mdo2_q   <= mdo1_q;
    j2_q     <= j1_q;
    sa_q     <= scale_step(ga_q, adapt_shift_q);
    sm_q     <= scale_step(gm_q, model_shift_q);
    la_q     <= leak64(ca_q, leak_shift_q);
    lm_q     <= leak64(cm_q, leak_shift_q);
    ado3_q   <= ado2_q;
    mdo3_q   <= mdo2_q;
    j3_q     <= j2_q;
    if (state_q == S_FIR_END) begin
      y_q  <= sat33_16(33'(signed'(acc_y_q[63:32])));
      es_q <= sat33_16(33'(e_q) - 33'(ys));
    end
    if (state_q == S_FIN && free_out) begin
      out_item_o.drive_sample <= proc_q ? y_q : '0;
      out_item_o.drive_valid  <= proc_q && vflag_q;
      out_item_o.model_error  <= proc_q ? es_q : '0;
    end
  end

  a_no_pipe_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !f1_v_q && !f2_v_q && !u1_v_q && !u2_v_q && !u3_v_q)
    else $error("tap pipeline busy while idle");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q >= $past(count_q))
    else $error("sample count went backwards");

  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= JW'(REF_DEPTH))
    else $error("tap counter out of range");

  a_update_after_fir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD && $past(state_q) != S_UPD |-> $past(state_q) == S_FIR_END)
    else $error("update pass entered without filter pass");

endmodule

`default_nettype wire
